>>> rtl/qva_pkg.sv
// shared types and constants for the quorum value aggregator
package qva_pkg;

    localparam int SLOTS  = 8;
    localparam int VAL_W  = 64;
    localparam int LANE_W = 3;   // bits to name one lane, and a rank among up to eight lanes
    localparam int CNT_W  = 4;   // member count, 0 to 8
    localparam int IDX_W  = 8;
    localparam int MASK_W = 8;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_MEMBER = 8'd0;
    localparam logic [IDX_W-1:0] REG_FORCE  = 8'd1;

    localparam logic [VAL_W-1:0] VAL_ONES = {VAL_W{1'b1}};

    // what one lane found about its slot
    typedef struct packed {
        logic              member;
        logic              forced;
        logic [LANE_W-1:0] rank;    // position among all members
        logic [LANE_W-1:0] frank;   // position among force-sync members
    } lane_t;

endpackage

>>> rtl/qva_lane.sv
// one slot lane: ranks its value against the other member slots
module qva_lane
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [qva_pkg::LANE_W-1:0]    lane_id,
    input  logic [qva_pkg::VAL_W-1:0]     values [qva_pkg::SLOTS],
    input  logic [qva_pkg::SLOTS-1:0]     member,
    input  logic [qva_pkg::SLOTS-1:0]     forced,
    output qva_pkg::lane_t                lane_reg,
    output logic [qva_pkg::VAL_W-1:0]     value_reg
);

    qva_pkg::lane_t              lane_next;
    logic [qva_pkg::VAL_W-1:0]   own;
    logic [qva_pkg::SLOTS-1:0]   ahead;

    assign own = values[lane_id];

    // slot j sorts ahead of this lane: smaller value, or equal value at a lower slot
    always_comb
    begin
        for (int j = 0; j < qva_pkg::SLOTS; j++)
        begin
            ahead[j] = (values[j] < own) ||
                       ((values[j] == own) && (qva_pkg::LANE_W'(j) < lane_id));
        end
    end

    always_comb
    begin
        lane_next.member = member[lane_id];
        lane_next.forced = forced[lane_id];
        lane_next.rank   = '0;
        lane_next.frank  = '0;
        for (int j = 0; j < qva_pkg::SLOTS; j++)
        begin
            if (qva_pkg::LANE_W'(j) != lane_id && ahead[j])
            begin
                if (member[j])
                begin
                    lane_next.rank = lane_next.rank + 1'b1;
                end
                if (forced[j])
                begin
                    lane_next.frank = lane_next.frank + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
        end
        else if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= own;
        end
    end

endmodule

>>> rtl/qva_merge.sv
// merge stage: picks the median and minimum lanes and registers the result
module qva_merge
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  qva_pkg::lane_t                lanes [qva_pkg::SLOTS],
    input  logic [qva_pkg::VAL_W-1:0]     values [qva_pkg::SLOTS],
    input  logic                          empty,
    input  logic [qva_pkg::LANE_W-1:0]    target,
    input  logic                          quorum,
    output logic                          done,
    output logic [qva_pkg::VAL_W-1:0]     quorum_value,
    output logic [qva_pkg::VAL_W-1:0]     all_minimum,
    output logic [qva_pkg::VAL_W-1:0]     forced_minimum,
    output logic                          quorum_reached
);

    logic                        done_reg;
    logic [qva_pkg::VAL_W-1:0]   qv_next, amin_next, fmin_next, qv_reg, amin_reg, fmin_reg;
    logic                        any_forced;
    logic                        quorum_reg;

    // ranks are unique among members, so each pick is a one-hot or of lanes
    always_comb
    begin
        qv_next    = '0;
        amin_next  = '0;
        fmin_next  = '0;
        any_forced = 1'b0;
        for (int i = 0; i < qva_pkg::SLOTS; i++)
        begin
            if (lanes[i].member && lanes[i].rank == target)
            begin
                qv_next = qv_next | values[i];
            end
            if (lanes[i].member && lanes[i].rank == '0)
            begin
                amin_next = amin_next | values[i];
            end
            if (lanes[i].forced && lanes[i].frank == '0)
            begin
                fmin_next = fmin_next | values[i];
            end
            any_forced = any_forced | lanes[i].forced;
        end
        if (!any_forced)
        begin
            fmin_next = qva_pkg::VAL_ONES;
        end
        if (empty)
        begin
            qv_next   = '0;
            amin_next = '0;
            fmin_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            qv_reg     <= qv_next;
            amin_reg   <= amin_next;
            fmin_reg   <= fmin_next;
            quorum_reg <= quorum | empty;
        end
    end

    assign done           = done_reg;
    assign quorum_value   = qv_reg;
    assign all_minimum    = amin_reg;
    assign forced_minimum = fmin_reg;
    assign quorum_reached = quorum_reg;

endmodule

>>> rtl/quorum_value_aggregator_top.sv
// top level of the quorum value aggregator
// path: a beat is registered in the rank lanes, then in the merge stage, which raises done with the result
// throughput: one beat per cycle, busy is never raised and the result path cannot stall
// pipeline: eight rank lanes (registered), then the merge stage (registered outputs)
// reset: rst_n clears both masks to zero and empties the pipeline
module quorum_value_aggregator_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    // command side
    input  logic                             start,
    output logic                             busy,
    input  logic [qva_pkg::VAL_W-1:0]        value_0,
    input  logic [qva_pkg::VAL_W-1:0]        value_1,
    input  logic [qva_pkg::VAL_W-1:0]        value_2,
    input  logic [qva_pkg::VAL_W-1:0]        value_3,
    input  logic [qva_pkg::VAL_W-1:0]        value_4,
    input  logic [qva_pkg::VAL_W-1:0]        value_5,
    input  logic [qva_pkg::VAL_W-1:0]        value_6,
    input  logic [qva_pkg::VAL_W-1:0]        value_7,
    input  logic [qva_pkg::MASK_W-1:0]       vote_mask,
    // result side, one cycle strobe
    output logic                             done,
    output logic [qva_pkg::VAL_W-1:0]        quorum_value,
    output logic [qva_pkg::VAL_W-1:0]        all_minimum,
    output logic [qva_pkg::VAL_W-1:0]        forced_minimum,
    output logic                             quorum_reached,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qva_pkg::IDX_W-1:0]        cfg_index,
    input  logic [qva_pkg::MASK_W-1:0]       cfg_data
);

    logic                              accept;
    logic [qva_pkg::MASK_W-1:0]        member_reg, member_next;
    logic [qva_pkg::MASK_W-1:0]        force_reg, force_next;
    logic [qva_pkg::SLOTS-1:0]         member, forced, votes;
    logic [qva_pkg::VAL_W-1:0]         in_values [qva_pkg::SLOTS];
    logic [qva_pkg::CNT_W-1:0]         k_cnt, yes_cnt, k_less;
    logic [qva_pkg::LANE_W-1:0]        target;
    logic                              quorum, empty;

    // stage one control, travels alongside the lane registers
    logic                              s1_valid_reg;
    logic                              s1_empty_reg;
    logic [qva_pkg::LANE_W-1:0]        s1_target_reg;
    logic                              s1_quorum_reg;

    qva_pkg::lane_t                    lanes [qva_pkg::SLOTS];
    logic [qva_pkg::VAL_W-1:0]         lane_values [qva_pkg::SLOTS];

    // no stall anywhere: a beat can be taken every cycle
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // configuration registers, indexes outside the list are dropped
    always_comb
    begin
        member_next = member_reg;
        force_next  = force_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                qva_pkg::REG_MEMBER: member_next = cfg_data;
                qva_pkg::REG_FORCE:  force_next  = cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_reg <= '0;
            force_reg  <= '0;
        end
        else
        begin
            member_reg <= member_next;
            force_reg  <= force_next;
        end
    end

    // effective masks: force-sync and votes only count on member slots
    assign member = member_reg[qva_pkg::SLOTS-1:0];
    assign forced = force_reg[qva_pkg::SLOTS-1:0] & member;
    assign votes  = vote_mask[qva_pkg::SLOTS-1:0] & member;

    assign in_values[0] = value_0;
    assign in_values[1] = value_1;
    assign in_values[2] = value_2;
    assign in_values[3] = value_3;
    assign in_values[4] = value_4;
    assign in_values[5] = value_5;
    assign in_values[6] = value_6;
    assign in_values[7] = value_7;

    // member and vote counts
    always_comb
    begin
        k_cnt   = '0;
        yes_cnt = '0;
        for (int i = 0; i < qva_pkg::SLOTS; i++)
        begin
            k_cnt   = k_cnt + qva_pkg::CNT_W'(member[i]);
            yes_cnt = yes_cnt + qva_pkg::CNT_W'(votes[i]);
        end
    end

    // median position (k-1)/2 and strict majority test
    assign k_less = k_cnt - 1'b1;
    assign target = k_less[qva_pkg::LANE_W:1];
    assign empty  = (k_cnt == '0);
    assign quorum = (yes_cnt >= ((k_cnt >> 1) + 1'b1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_empty_reg  <= empty;
            s1_target_reg <= target;
            s1_quorum_reg <= quorum;
        end
    end

    // one rank lane per slot, each compares its value to all others
    for (genvar g = 0; g < qva_pkg::SLOTS; g++)
    begin : g_lane
        qva_lane u_lane
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (accept),
            .lane_id   (qva_pkg::LANE_W'(g)),
            .values    (in_values),
            .member    (member),
            .forced    (forced),
            .lane_reg  (lanes[g]),
            .value_reg (lane_values[g])
        );
    end

    // merge the lane ranks into the four result fields
    qva_merge u_merge
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .valid_in       (s1_valid_reg),
        .lanes          (lanes),
        .values         (lane_values),
        .empty          (s1_empty_reg),
        .target         (s1_target_reg),
        .quorum         (s1_quorum_reg),
        .done           (done),
        .quorum_value   (quorum_value),
        .all_minimum    (all_minimum),
        .forced_minimum (forced_minimum),
        .quorum_reached (quorum_reached)
    );

endmodule
